// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent and consequent form, built on the macro above.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/bfil_pkg.sv =====
// Package: types, constants and register indexes of the bloom-filtered lookup.
`timescale 1ns / 1ps

package bfil_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int HASHES_DEF  = 3;

  localparam int WORD_W  = 64;
  localparam int ID_W    = 256;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int BLOOM_W = 256;
  localparam int CRC_W   = 32;
  localparam int IDX_W   = 6;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BLOOM0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOOM1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOOM2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLOOM3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] id_word0;
    logic [WORD_W-1:0] id_word1;
    logic [WORD_W-1:0] id_word2;
    logic [WORD_W-1:0] id_word3;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             bloom_pass;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic              is_lookup;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              bloom_pass;
  } q_item_t;

endpackage

// ===== hw/rtl/bfil_fifo.sv =====
// Small queue of classified operations between the front and the back.
`timescale 1ns / 1ps

module bfil_fifo
  import bfil_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t head_item,
  output logic    empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t        slots_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(QDEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/bfil_front.sv =====
// Front part: accepts requests, runs the CRC one byte per cycle and checks the bloom filter.
`timescale 1ns / 1ps

module bfil_front
  import bfil_pkg::*;
#(
  parameter int HASHES = HASHES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  in_item_t           in_item,
  output logic               in_full,
  input  logic [BLOOM_W-1:0] bloom_vec,
  output logic               q_push,
  output q_item_t            q_item,
  input  logic               q_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  localparam int BCNT_W = $clog2(ID_W / BYTE_W);

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ CRC_W'(data);
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [BCNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  in_item_t          item_r;
  logic [ID_W-1:0]   id_flat;
  logic [BYTE_W-1:0] cur_byte;
  logic [CRC_W-1:0]  crc_fin;
  logic              pass;
  logic              accept;

  assign in_full  = (state_r != ST_IDLE);
  assign accept   = in_push && !in_full;
  assign id_flat  = {item_r.id_word3, item_r.id_word2, item_r.id_word1, item_r.id_word0};
  assign cur_byte = id_flat[{byte_cnt_r, 3'b000} +: BYTE_W] & BYTE_MASK;
  assign crc_fin  = ~crc_r;

  // Each hash takes one byte of the final CRC as a bit index into the filter.
  always_comb begin
    pass = 1'b1;
    for (int h = 0; h < HASHES; h++) begin
      pass = pass & bloom_vec[crc_fin[h*BYTE_W +: BYTE_W]];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    byte_cnt_nxt = byte_cnt_r;
    crc_nxt      = crc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          byte_cnt_nxt = '0;
          crc_nxt      = CRC_INIT;
          state_nxt    = (in_item.req_type == REQ_LOOKUP) ? ST_CRC : ST_PUSH;
        end
      end
      ST_CRC: begin
        crc_nxt      = crc_byte(crc_r, cur_byte);
        byte_cnt_nxt = byte_cnt_r + 1'b1;
        if (byte_cnt_r == '1) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_cnt_r <= '0;
      crc_r      <= CRC_INIT;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign q_push            = (state_r == ST_PUSH);
  assign q_item.is_lookup  = (item_r.req_type == REQ_LOOKUP);
  assign q_item.slot       = item_r.slot;
  assign q_item.id         = id_flat;
  assign q_item.bloom_pass = (item_r.req_type == REQ_LOOKUP) && pass;

endmodule

// ===== hw/rtl/bfil_back.sv =====
// Back part: entry store, sequential table scan and the result register.
`timescale 1ns / 1ps

module bfil_back
  import bfil_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] entry_count,
  input  q_item_t            q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_empty,
  output out_item_t          out_item,
  input  logic               out_pop
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int XW = (IW > IDX_W) ? IW : IDX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [ID_W-1:0] store [ENTRIES];
  logic [ID_W-1:0] rd_data_r;
  logic [ID_W-1:0] key_r;
  logic [IW-1:0]   rd_addr;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic          pend_found_r, pend_found_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pend_pass_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;

  logic [LW-1:0] count_ext;
  logic [CW-1:0] limit_cur;
  logic          is_last;
  logic          hit;
  logic          do_load;
  logic          start_lookup;
  logic          out_load;
  logic [XW-1:0] idx_ext;

  // The scan never runs past the end of the store, whatever the count says.
  assign count_ext = LW'(entry_count);
  assign limit_cur = (count_ext > LW'(ENTRIES)) ? CW'(ENTRIES) : CW'(count_ext);

  assign q_pop        = (state_r == ST_IDLE) && !q_empty;
  assign do_load      = q_pop && !q_head.is_lookup;
  assign start_lookup = q_pop && q_head.is_lookup;
  assign hit          = (rd_data_r == key_r);
  assign is_last      = ((CW + 1)'(idx_r) + 1'b1) == (CW + 1)'(limit_r);
  assign out_load     = (state_r == ST_RESULT) && (!out_valid_r || out_pop);

  // The read data register always holds the entry at idx_r while scanning.
  assign rd_addr = (state_r == ST_SCAN) ? IW'(idx_r + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (do_load && (32'(q_head.slot) < 32'(ENTRIES))) begin
      store[IW'(q_head.slot)] <= q_head.id;
    end
    rd_data_r <= store[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    limit_nxt      = limit_r;
    pend_found_nxt = pend_found_r;
    pend_idx_nxt   = pend_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_lookup) begin
          pend_found_nxt = 1'b0;
          pend_idx_nxt   = '0;
          idx_nxt        = '0;
          limit_nxt      = limit_cur;
          if (q_head.bloom_pass && (limit_cur != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pend_found_nxt = 1'b1;
          pend_idx_nxt   = idx_r;
          state_nxt      = ST_RESULT;
        end else if (is_last) begin
          state_nxt = ST_RESULT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      limit_r      <= '0;
      pend_found_r <= 1'b0;
      pend_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      limit_r      <= limit_nxt;
      pend_found_r <= pend_found_nxt;
      pend_idx_r   <= pend_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign idx_ext = XW'(pend_idx_r);

  always_ff @(posedge clk) begin
    if (start_lookup) begin
      key_r       <= q_head.id;
      pend_pass_r <= q_head.bloom_pass;
    end
    if (out_load) begin
      out_item_r.found       <= pend_found_r;
      out_item_r.found_index <= idx_ext[IDX_W-1:0];
      out_item_r.bloom_pass  <= pend_pass_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/bloom_filtered_id_lookup.sv =====
// Top level: configuration registers, front part, operation queue and back part.
`timescale 1ns / 1ps

// Bloom-filtered identifier lookup. A load beat writes a 256-bit identifier
// into the entry store and gives no result; a lookup beat gives exactly one
// result. The front part takes a beat and, for a lookup, runs the CRC-32 one
// byte per cycle; the back part then, for a lookup that passes the bloom
// filter, scans the entry store one entry per cycle through its single read
// port, over at most min(entry_count, ENTRIES) entries. A two-deep queue
// between the parts and the result register let the front accept new beats
// while a result waits. The entry store has no reset and no clearing pass: an
// entry must be loaded before any lookup can scan it. Configuration writes are
// taken at any time but must only be issued while the block is idle.

module bloom_filtered_id_lookup
  import bfil_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int HASHES  = HASHES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_item,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  logic [WORD_W-1:0]  bloom0_r, bloom1_r, bloom2_r, bloom3_r;
  logic [COUNT_W-1:0] entry_count_r;
  logic               cfg_we;

  q_item_t front_item;
  q_item_t head_item;
  logic    front_push;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bloom0_r      <= '0;
      bloom1_r      <= '0;
      bloom2_r      <= '0;
      bloom3_r      <= '0;
      entry_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOOM0: bloom0_r <= cfg_wdata;
        REG_BLOOM1: bloom1_r <= cfg_wdata;
        REG_BLOOM2: bloom2_r <= cfg_wdata;
        REG_BLOOM3: bloom3_r <= cfg_wdata;
        REG_COUNT:  entry_count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bfil_front #(
    .HASHES (HASHES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .bloom_vec ({bloom3_r, bloom2_r, bloom1_r, bloom0_r}),
    .q_push    (front_push),
    .q_item    (front_item),
    .q_full    (q_full)
  );

  bfil_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  bfil_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_count (entry_count_r),
    .q_head      (head_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_item    (out_item),
    .out_pop     (out_pop)
  );

endmodule

// ===== hw/rtl/bfil_checker.sv =====
// Port-level checker for the bloom-filtered lookup, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfil_checker
  import bfil_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // A waiting result that is not taken stays on the ports unchanged.
  `ASSERT_IMPL(a_result_holds, !out_empty && !out_pop, ##1 (!out_empty && $stable(out_item)), "result changed before it was taken")

  // A match can only follow a bloom filter pass.
  `ASSERT_IMPL(a_found_needs_pass, !out_empty && out_item.found, out_item.bloom_pass, "found without bloom pass")

  // The index reads zero whenever nothing matched.
  `ASSERT_IMPL(a_index_zero_on_miss, !out_empty && !out_item.found, out_item.found_index == '0, "nonzero index on a miss")

  // A beat pushed into the front part leaves it busy in the next cycle.
  `ASSERT_IMPL(a_push_busy, in_push && !in_full, ##1 in_full, "front not busy after an accepted beat")

  // The configuration port never back-pressures.
  `ASSERT_CLK(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind bloom_filtered_id_lookup bfil_checker u_bfil_checker (.*);
